// ===== sv/ilfd_pkg.sv =====
// Package for the IPv4 longest-prefix-match forwarding core.
// Holds request/result structs, request and verdict codes, controller commands and datapath status.
`timescale 1ns / 1ps
package ilfd_pkg;
  localparam int TableDepthDefault = 16;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_WORD  = 2'd2;

  localparam logic [2:0] VERDICT_LOCAL   = 3'd0;
  localparam logic [2:0] VERDICT_FORWARD = 3'd1;
  localparam logic [2:0] VERDICT_TTL     = 3'd2;
  localparam logic [2:0] VERDICT_NOROUTE = 3'd3;
  localparam logic [2:0] VERDICT_FULL    = 3'd4;

  localparam logic [16:0] SumModulus = 17'd65535;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] route_dest;
    logic [5:0]  route_prefix_len;
    logic [31:0] route_next_hop;
    logic [15:0] header_word;
    logic        last_word;
  } request_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] next_hop;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic take_request;  // register the request and process word/add/clear
    logic search_start;  // reset the search cursor and best match
    logic search_step;   // examine one table entry
    logic emit;          // reserved; the controller never sets it and the datapath does not read it
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_search;   // the last word needs a table search
    logic immediate;     // request yields a result without search
    logic search_done;   // cursor has passed the final entry
  } dp_status_t;
endpackage

// ===== sv/ilfd_ram.sv =====
// Generic single-port-write RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ilfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/ilfd_datapath.sv =====
// Datapath: header parsing, checksum, route table and serial prefix search.
// Depends on ilfd_pkg and ilfd_ram.
`timescale 1ns / 1ps
module ilfd_datapath #(
  parameter int TableDepth = ilfd_pkg::TableDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ilfd_pkg::request_t   req,
  input  logic [31:0]          own_address,
  input  ilfd_pkg::dp_cmd_t    cmd,
  output ilfd_pkg::dp_status_t status,
  output ilfd_pkg::result_t    result
);
  localparam int AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CountW = $clog2(TableDepth + 1);
  localparam int RamDepth = 1 << AddrW;

  logic [CountW-1:0] entry_count;
  logic [4:0]        word_index;
  logic [3:0]        header_length;
  logic [7:0]        held_ttl;
  logic [31:0]       held_destination;
  logic [16:0]       sum_accumulator;

  // Decision side, captured when a last word is taken (the verdict also on a full-table add).
  logic [31:0]       dec_dest;
  logic [7:0]        dec_ttl;
  logic [15:0]       dec_sum;
  logic [2:0]        dec_verdict;
  logic              need_search;
  logic              immediate;

  logic [CountW-1:0] cursor;
  logic              cursor_valid;  // RAM read data belongs to cursor-1
  logic              found;
  logic [5:0]        best_len;
  logic [31:0]       best_hop;

  logic [69:0]       ram_wdata;
  logic [69:0]       ram_rdata;
  logic [AddrW-1:0]  ram_raddr;
  logic              ram_we;

  logic [5:0]        add_len;
  logic              table_full;
  logic [15:0]       term;
  logic [16:0]       sum_raw;
  logic [16:0]       sum_red;
  logic [15:0]       w;
  logic [7:0]        ttl_now;
  logic [31:0]       dest_now;
  logic [3:0]        hl_now;
  logic              sum_en;

  assign add_len    = (req.route_prefix_len > 6'd32) ? 6'd32 : req.route_prefix_len;
  assign table_full = (entry_count >= CountW'(TableDepth));
  assign ram_we     = cmd.take_request && (req.req_type == ilfd_pkg::REQ_ADD) && !table_full;
  assign ram_wdata  = {req.route_dest, add_len, req.route_next_hop};
  assign ram_raddr  = cursor[AddrW-1:0];

  ilfd_ram #(.Width(70), .Depth(RamDepth)) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(entry_count[AddrW-1:0]),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign w = req.header_word;
  always_comb begin
    ttl_now  = (word_index == 5'd4) ? w[15:8] : held_ttl;
    // The first word sets the header length that already bounds its own sum.
    hl_now   = (word_index == 5'd0) ? w[11:8] : header_length;
    dest_now = held_destination;
    if (word_index == 5'd8) begin
      dest_now[31:16] = w;
    end
    if (word_index == 5'd9) begin
      dest_now[15:0] = w;
    end
    sum_en  = (word_index != 5'd5) && ({1'b0, word_index} < {1'b0, hl_now, 1'b0});
    term    = w;
    if (word_index == 5'd4 && w[15:8] != 8'd0) begin
      term = w - 16'h0100;
    end
    sum_raw = sum_accumulator + {1'b0, term};
    sum_red = (sum_raw >= ilfd_pkg::SumModulus) ? sum_raw - ilfd_pkg::SumModulus : sum_raw;
    if (!sum_en) begin
      sum_red = sum_accumulator;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count      <= '0;
      word_index       <= '0;
      header_length    <= '0;
      held_ttl         <= '0;
      held_destination <= '0;
      sum_accumulator  <= '0;
      dec_verdict      <= ilfd_pkg::VERDICT_LOCAL;
      need_search      <= 1'b0;
      immediate        <= 1'b0;
    end else if (cmd.take_request) begin
      immediate   <= 1'b0;
      need_search <= 1'b0;
      case (req.req_type)
        ilfd_pkg::REQ_CLEAR: begin
          entry_count <= '0;
        end
        ilfd_pkg::REQ_ADD: begin
          if (table_full) begin
            dec_verdict <= ilfd_pkg::VERDICT_FULL;
            immediate   <= 1'b1;
          end else begin
            entry_count <= entry_count + 1'b1;
          end
        end
        ilfd_pkg::REQ_WORD: begin
          if (req.last_word) begin
            word_index       <= '0;
            header_length    <= '0;
            held_ttl         <= '0;
            held_destination <= '0;
            sum_accumulator  <= '0;
            dec_dest         <= dest_now;
            dec_ttl          <= ttl_now;
            dec_sum          <= ~sum_red[15:0];
            if (dest_now == own_address) begin
              dec_verdict <= ilfd_pkg::VERDICT_LOCAL;
              immediate   <= 1'b1;
            end else if (ttl_now == 8'd0) begin
              dec_verdict <= ilfd_pkg::VERDICT_TTL;
              immediate   <= 1'b1;
            end else begin
              need_search <= 1'b1;
            end
          end else begin
            header_length    <= hl_now;
            held_ttl         <= ttl_now;
            held_destination <= dest_now;
            sum_accumulator  <= sum_red;
            if (word_index != 5'd31) begin
              word_index <= word_index + 5'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Serial search: one entry a cycle, each RAM read registered in the cycle before its compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor       <= '0;
      cursor_valid <= 1'b0;
      found        <= 1'b0;
      best_len     <= '0;
    end else if (cmd.search_start) begin
      cursor       <= '0;
      cursor_valid <= 1'b0;
      found        <= 1'b0;
      best_len     <= '0;
    end else if (cmd.search_step) begin
      cursor_valid <= (cursor < entry_count);
      if (cursor < entry_count) begin
        cursor <= cursor + 1'b1;
      end
      if (cursor_valid) begin
        if (ram_rdata[37:32] > best_len && ram_rdata[37:32] != 6'd0 &&
            ram_rdata[69:38] == (dec_dest & ~(32'hFFFF_FFFF >> ram_rdata[37:32]))) begin
          found    <= 1'b1;
          best_len <= ram_rdata[37:32];
          best_hop <= ram_rdata[31:0];
        end
      end
    end
  end

  assign status = {need_search, immediate, !cursor_valid && (cursor >= entry_count)};

  always_comb begin
    result = '0;
    if (immediate && !need_search) begin
      result.verdict = dec_verdict;
    end else if (found) begin
      result.verdict      = ilfd_pkg::VERDICT_FORWARD;
      result.next_hop     = best_hop;
      result.new_ttl      = dec_ttl - 8'd1;
      result.new_checksum = dec_sum;
    end else begin
      result.verdict = ilfd_pkg::VERDICT_NOROUTE;
    end
  end
endmodule

// ===== sv/ilfd_controller.sv =====
// Controller state machine: sequences request intake, table search and result.
// Depends on ilfd_pkg.
`timescale 1ns / 1ps
module ilfd_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ilfd_pkg::dp_status_t status,
  output ilfd_pkg::dp_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.take_request = 1'b1;
          state_next       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.immediate) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end else if (status.need_search) begin
          cmd.search_start = 1'b1;
          state_next       = S_SEARCH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (status.search_done) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== sv/ipv4_lpm_forward_decision_core.sv =====
// A request is taken in the idle state and checked in the next cycle; the core
// stays busy and takes no new request until it returns to idle. A last header
// word that needs a route search first steps through the table entries, with the
// table RAM read once per cycle.
// Results appear for one cycle on result_valid; the receiver cannot stall.
// Synchronous active-high reset empties the table and the header state.
`timescale 1ns / 1ps
module ipv4_lpm_forward_decision_core #(
  parameter int TableDepth = ilfd_pkg::TableDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ilfd_pkg::request_t request,
  output logic               result_valid,
  output ilfd_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  // The own address register; the user must write it only while the core is idle, which the core does not enforce.
  logic [31:0] own_address;

  ilfd_pkg::dp_cmd_t    cmd;
  ilfd_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      own_address <= cfg_data;
    end
  end

  // The controller sequences each request; the datapath holds all payload.
  ilfd_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (result_valid)
  );

  ilfd_datapath #(.TableDepth(TableDepth)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .req        (request),
    .own_address(own_address),
    .cmd        (cmd),
    .status     (status),
    .result     (result)
  );
endmodule

// ===== sv/ilfd_checker.sv =====
// Port-level checker for the forwarding core, bound to the top level.
// Depends on ilfd_pkg.
`timescale 1ns / 1ps
module ilfd_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input ilfd_pkg::result_t result
);
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result outside a request");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted request not busy");
  a_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("repeated result");
  a_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.verdict != ilfd_pkg::VERDICT_FORWARD) |->
    (result.next_hop == 32'd0 && result.new_ttl == 8'd0)) else $error("stray fields");
endmodule

bind ipv4_lpm_forward_decision_core ilfd_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .result_valid(result_valid), .result(result)
);

// ===== tb/sv/ipv4_lpm_forward_decision_core_test.sv =====
// Testbench for the IPv4 longest-prefix-match forwarding core.
// Depends on ilfd_pkg and ipv4_lpm_forward_decision_core; drives requests, checks results.
`timescale 1ns / 1ps
module ipv4_lpm_forward_decision_core_test;
  localparam int Depth = ilfd_pkg::TableDepthDefault;
  localparam longint CycleLimit = 400000;

  // Scoreboard: holds its own copy of the route table and header state, predicts
  // the decision for every accepted request and compares results in order.
  class route_scoreboard;
    logic [31:0]          own_addr;
    logic [31:0]          tbl_prefix[Depth];
    logic [5:0]           tbl_len[Depth];
    logic [31:0]          tbl_hop[Depth];
    int                   tbl_count;
    int                   word_pos;
    logic [3:0]           ihl;
    logic [7:0]           ttl;
    logic [31:0]          dest;
    int                   csum;
    ilfd_pkg::result_t    pending[$];
    int                   errors;

    function new();
      own_addr = '0;
      tbl_count = 0;
      errors = 0;
      drop_header();
    endfunction

    function void drop_header();
      word_pos = 0;
      ihl = '0;
      ttl = '0;
      dest = '0;
      csum = 0;
    endfunction

    function logic [31:0] mask_of(logic [5:0] len);
      if (len == 0) return '0;
      return ~(32'hffff_ffff >> len);
    endfunction

    // Notes one accepted request and queues the result it causes, if any.
    function void note_request(ilfd_pkg::request_t rq);
      ilfd_pkg::result_t r;
      logic [5:0] len;
      int best;
      int best_len;
      int term;
      r = '0;
      case (rq.req_type)
        ilfd_pkg::REQ_CLEAR: tbl_count = 0;
        ilfd_pkg::REQ_ADD: begin
          len = (rq.route_prefix_len > 32) ? 6'd32 : rq.route_prefix_len;
          if (tbl_count >= Depth) begin
            r.verdict = ilfd_pkg::VERDICT_FULL;
            pending = {pending, r};
          end else begin
            tbl_prefix[tbl_count] = rq.route_dest;
            tbl_len[tbl_count] = len;
            tbl_hop[tbl_count] = rq.route_next_hop;
            tbl_count++;
          end
        end
        ilfd_pkg::REQ_WORD: begin
          if (word_pos == 0) ihl = rq.header_word[11:8];
          if (word_pos == 4) ttl = rq.header_word[15:8];
          if (word_pos == 8) dest[31:16] = rq.header_word;
          if (word_pos == 9) dest[15:0] = rq.header_word;
          if (word_pos != 5 && word_pos < 2 * ihl) begin
            term = int'(rq.header_word);
            // The sum is taken with the TTL already decremented.
            if (word_pos == 4 && ttl > 0) term -= 'h100;
            csum += term;
            if (csum >= 65535) csum -= 65535;
          end
          if (word_pos < 31) word_pos++;
          if (rq.last_word) begin
            if (dest == own_addr) begin
              r.verdict = ilfd_pkg::VERDICT_LOCAL;
            end else if (ttl == 0) begin
              r.verdict = ilfd_pkg::VERDICT_TTL;
            end else begin
              best = -1;
              best_len = 0;
              for (int i = 0; i < tbl_count; i++) begin
                if (tbl_len[i] > best_len && tbl_prefix[i] == (dest & mask_of(tbl_len[i]))) begin
                  best = i;
                  best_len = int'(tbl_len[i]);
                end
              end
              if (best >= 0) begin
                r.verdict = ilfd_pkg::VERDICT_FORWARD;
                r.next_hop = tbl_hop[best];
                r.new_ttl = ttl - 8'd1;
                r.new_checksum = ~csum[15:0];
              end else begin
                r.verdict = ilfd_pkg::VERDICT_NOROUTE;
              end
            end
            pending = {pending, r};
            drop_header();
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    // Checks one result against the oldest prediction, field by field.
    task check_result(ilfd_pkg::result_t got);
      ilfd_pkg::result_t want;
      if (pending.size() == 0) begin
        report("unexpected result verdict", 32'(got.verdict), 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got.verdict !== want.verdict)
        report("verdict", 32'(got.verdict), 32'(want.verdict));
      if (got.next_hop !== want.next_hop) report("next_hop", got.next_hop, want.next_hop);
      if (got.new_ttl !== want.new_ttl)
        report("new_ttl", 32'(got.new_ttl), 32'(want.new_ttl));
      if (got.new_checksum !== want.new_checksum)
        report("new_checksum", 32'(got.new_checksum), 32'(want.new_checksum));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  ilfd_pkg::request_t request;
  logic               result_valid;
  ilfd_pkg::result_t  result;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_data;

  route_scoreboard board;
  longint cycles;
  int idle_pct;
  int sent;
  // Routes added so far, reused so that header destinations often match.
  logic [31:0] known_dest[$];

  ipv4_lpm_forward_decision_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Results cannot be held off, so every strobed cycle is checked at its edge.
  always @(posedge clk) begin
    if (!rst && result_valid) board.check_result(result);
  end

  // A generous watchdog: every item at its slowest search plus sender gaps.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Random bits for every field, used where the fields must be ignored.
  function ilfd_pkg::request_t noise_request();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(ilfd_pkg::request_t)-1:0];
  endfunction

  // Presents one request and holds it until the block accepts it. The start
  // line stays high between back-to-back requests to avoid a double update.
  task send(ilfd_pkg::request_t rq);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(rq);
    sent++;
  endtask

  task stop_sending();
    start <= 1'b0;
    request <= '0;
    @(posedge clk);
  endtask

  // Waits for every predicted result, then lets a full search time pass.
  task drain();
    stop_sending();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Depth + 8) @(posedge clk);
  endtask

  // Writes the own address; the block must be idle beforehand.
  task write_own(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.own_addr = v;
  endtask

  task add_route(logic [31:0] d, logic [5:0] len, logic [31:0] hop);
    ilfd_pkg::request_t rq;
    rq = '0;
    rq.req_type = ilfd_pkg::REQ_ADD;
    rq.route_dest = d;
    rq.route_prefix_len = len;
    rq.route_next_hop = hop;
    // Foreign fields carry noise, which the block must ignore.
    rq.header_word = 16'($urandom);
    rq.last_word = 1'($urandom_range(1));
    send(rq);
    known_dest = {known_dest, d};
  endtask

  task clear_table();
    ilfd_pkg::request_t rq;
    rq = noise_request();
    rq.req_type = ilfd_pkg::REQ_CLEAR;
    send(rq);
  endtask

  task word(logic [15:0] w, logic last);
    ilfd_pkg::request_t rq;
    rq = noise_request();
    rq.req_type = ilfd_pkg::REQ_WORD;
    rq.header_word = w;
    rq.last_word = last;
    send(rq);
  endtask

  // Sends a header of n words with the given IHL, TTL and destination.
  task header(int n, logic [3:0] hl, logic [7:0] tl, logic [31:0] d);
    logic [15:0] w;
    for (int i = 0; i < n; i++) begin
      w = 16'($urandom);
      if (i == 0) w[11:8] = hl;
      if (i == 4) w[15:8] = tl;
      if (i == 8) w = d[31:16];
      if (i == 9) w = d[15:0];
      word(w, i == n - 1);
    end
  endtask

  function logic [31:0] pick_dest();
    logic [31:0] d;
    d = $urandom;
    if (known_dest.size() != 0 && $urandom_range(99) < 75) begin
      d = known_dest[$urandom_range(known_dest.size() - 1)];
      // Disturb low bits so that shorter prefixes win at times.
      if ($urandom_range(1)) d[7:0] = 8'($urandom);
    end
    return d;
  endfunction

  task random_request();
    ilfd_pkg::request_t rq;
    int n;
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) begin
      clear_table();
      known_dest.delete();
    end else if (pick < 18) begin
      add_route($urandom, 6'($urandom_range(63)), $urandom);
    end else if (pick < 22) begin
      // Random noise, including the unused request type.
      rq = noise_request();
      if (rq.req_type == ilfd_pkg::REQ_CLEAR) rq.req_type = 2'd3;
      send(rq);
    end else if (pick < 28) begin
      n = $urandom_range(1, 12);
      header(n, 4'($urandom), 8'($urandom), pick_dest());
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(10, 12);
      header(n, $urandom_range(99) < 80 ? 4'(5 + $urandom_range(1)) : 4'($urandom),
             ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom),
             ($urandom_range(19) == 0) ? board.own_addr : pick_dest());
    end
  endtask

  initial begin
    board = new();
    cycles = 0;
    sent = 0;
    idle_pct = 17;
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: extremes of routes, a full table, every verdict.
    write_own(32'hffff_ffff);
    add_route(32'h0a00_0000, 6'd8, 32'h0101_0101);
    add_route(32'h0a01_0000, 6'd16, 32'h0202_0202);
    add_route(32'h0a01_0000, 6'd16, 32'h0303_0303);   // tie, earlier wins
    add_route(32'h0000_0000, 6'd0, 32'h0404_0404);    // never matches
    add_route(32'h0a01_0203, 6'd63, 32'hffff_ffff);   // length saturates
    header(10, 4'd5, 8'd64, 32'h0a01_0203);
    header(10, 4'd5, 8'd1, 32'h0a01_0999);
    header(10, 4'd5, 8'd255, 32'h0b00_0000);
    header(10, 4'd5, 8'd0, 32'h0a00_0001);
    header(10, 4'd15, 8'd9, 32'hffff_ffff);           // local
    header(3, 4'd0, 8'd9, 32'h0);                     // short header
    for (int i = 0; i < Depth; i++) add_route($urandom, 6'($urandom_range(32)), $urandom);
    drain();
    write_own(32'h0000_0000);
    header(1, 4'd5, 8'd0, 32'h0);                     // zero destination is local
    clear_table();
    add_route(32'h0, 6'd1, 32'h5555_aaaa);
    header(36, 4'd15, 8'd200, 32'h7fff_ffff);         // long header

    // Random part in phases with fresh own addresses.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_own($urandom);
      // The third phase runs without any sender idling.
      idle_pct = (ph == 2) ? 0 : 17;
      while (sent < 200 * (ph + 1)) random_request();
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
